/* hdl/epbc_pkg.sv */
// shared types and constants of the equal-population bin center unit
// no dependencies: compiled first, used by every other file but epbc_if
package epbc_pkg;

  localparam int ValW  = 24;  // signed value field
  localparam int OccW  = 32;  // occurrence count field
  localparam int PopW  = 40;  // population counts
  localparam int SumW  = 64;  // weighted sum accumulator
  localparam int CntW  = 17;  // center counts
  localparam int SlotW = 16;  // slot and fill fields
  localparam int ProdW = ValW + OccW + 1;

  localparam logic [CntW-1:0] MaxCenters   = 17'd65536;
  localparam logic [CntW-1:0] CenterReset  = 17'd256;
  localparam logic [ValW-1:0] PosLimit     = 24'h7FFFFF;
  localparam logic [ValW-1:0] NegLimit     = 24'h800000;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CENTER_TOTAL     = 1'b0,
    REG_POPULATION_TOTAL = 1'b1
  } epbc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MEAN_DIV,
    ST_EMIT,
    ST_OPEN,
    ST_TGT_DIV,
    ST_TAIL
  } epbc_state_e;

  // what kind of result the emit step writes
  typedef enum logic [1:0] {
    EMIT_CLOSE,
    EMIT_LAST_CLOSE,
    EMIT_MARKER
  } epbc_emit_e;

  typedef struct packed {
    logic       take_item;
    logic       add_item;
    logic       mean_start;
    logic       tgt_start;
    logic       open_bin;
    logic       emit;
    epbc_emit_e emit_kind;
    logic       reload;
  } epbc_cmd_t;

  typedef struct packed {
    logic bin_open;
    logic joins;
    logic can_open;
    logic last_item;
    logic div_done;
    logic out_free;
  } epbc_stat_t;

endpackage

/* hdl/epbc_if.sv */
// valid/ready channel interfaces for input pairs and result beats
// no dependencies
interface epbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_value;
  logic        [31:0] occurrences;
  logic               final_item;

  modport source (output valid, output sample_value, output occurrences,
                  output final_item, input ready);
  modport sink (input valid, input sample_value, input occurrences,
                input final_item, output ready);
endinterface

interface epbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] center_value;
  logic        [15:0] center_slot;
  logic        [15:0] infinite_fill;
  logic               run_end;

  modport source (output valid, output center_value, output center_slot,
                  output infinite_fill, output run_end, input ready);
  modport sink (input valid, input center_value, input center_slot,
                input infinite_fill, input run_end, output ready);
endinterface

/* hdl/equal_population_bin_centers_unit.sv */
// top level of the equal-population bin center unit
// depends on epbc_pkg, epbc_if, epbc_ctrl, epbc_dp (which holds epbc_div)
//
// groups (value, count) pairs, sorted ascending by value, into bins of about
// equal population and returns one beat per closed bin with its count-weighted
// mean (q7.16, truncated toward zero, saturated), its slot in the center table,
// and on the last beat of a stream the number of centers left to fill with
// infinity plus the run_end flag. a pair that joins the open bin is accepted
// with the value*count multiply, then takes the join decision and accumulate.
// a pair that closes a bin then passes a mean divide and the emit step, and one
// that opens a bin passes the open check, a target divide and the tail step; a
// close that cannot open a new bin still passes the open check and the tail step.
// both the bin mean and the new bin target run through one shared restoring
// divider that makes one quotient bit per cycle over a 64-bit dividend. the
// final pair adds one more mean divide and emit step when a bin is still open.
// at most one result beat is held in the output register; input is taken again
// while it waits, and an emit step stalls until the held beat is taken.
// configuration writes (center_total, population_total) reload the stream
// state and abandon any open bin; write them only while the unit is idle.
module equal_population_bin_centers_unit import epbc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [PopW-1:0]  cfg_data_i,
  epbc_in_if.sink          in_if,
  epbc_out_if.source       out_if
);

  // command and status between sequencer and datapath
  epbc_cmd_t  cmd;
  epbc_stat_t stat;

  epbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // pair payload goes straight into the datapath's item registers on accept
  epbc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_value_i  (in_if.sample_value),
    .occurrences_i   (in_if.occurrences),
    .final_item_i    (in_if.final_item),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_if.valid),
    .center_value_o  (out_if.center_value),
    .center_slot_o   (out_if.center_slot),
    .infinite_fill_o (out_if.infinite_fill),
    .run_end_o       (out_if.run_end),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

/* hdl/epbc_div.sv */
// restoring divider, one quotient bit per cycle, 64-bit dividend by 40-bit divisor
// depends on epbc_pkg
module epbc_div import epbc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [PopW-1:0] divisor_i,
  output logic            done_o,
  output logic [SumW-1:0] quotient_o
);

  localparam int StepW = $clog2(SumW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PopW-1:0]  rem_q, rem_d;
  logic [PopW-1:0]  dvs_q, dvs_d;
  logic [SumW-1:0]  quo_q, quo_d;
  logic [PopW:0]    shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[SumW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? PopW'(shifted - {1'b0, dvs_q}) : shifted[PopW-1:0];
      quo_d  = {quo_q[SumW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == {StepW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hdl/epbc_dp.sv */
// datapath: configuration, bin state, multiplier, shared divider, result register
// depends on epbc_pkg and epbc_div
module epbc_dp import epbc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [PopW-1:0]        cfg_data_i,
  input  logic signed [ValW-1:0] sample_value_i,
  input  logic [OccW-1:0]        occurrences_i,
  input  logic                   final_item_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [ValW-1:0] center_value_o,
  output logic [SlotW-1:0]       center_slot_o,
  output logic [SlotW-1:0]       infinite_fill_o,
  output logic                   run_end_o,
  input  epbc_cmd_t              cmd_i,
  output epbc_stat_t             stat_o
);

  // configuration
  logic [CntW-1:0] ct_q, ct_d;
  logic [PopW-1:0] pt_q, pt_d;
  // bin state
  logic [SumW-1:0] ws_q, ws_d;
  logic [PopW-1:0] pop_q, pop_d;
  logic [PopW-1:0] tgt_q, tgt_d;
  logic [PopW-1:0] una_q, una_d;
  logic [CntW-1:0] cl_q, cl_d;
  logic            open_q, open_d;
  // held item
  logic signed [ProdW-1:0] prod_q;
  logic [OccW-1:0]         occ_q;
  logic                    last_q;
  // result register
  logic                   ov_q, ov_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [SlotW-1:0]       fill_q, fill_d;
  logic                   end_q, end_d;

  logic [SumW-1:0] prod_ext, mag, div_a, quo;
  logic [PopW-1:0] div_b, shortfall;
  logic [PopW:0]   pop_sum, pop_sum_add;
  logic [CntW-1:0] ct_load, ct_new, slot_now, cl_dec;
  logic [SumW-1:0] q_mean;
  logic [ValW-1:0] mean_val;
  logic            div_start, div_done, joins, out_free;

  function automatic logic [CntW-1:0] clamp_centers(input logic [CntW-1:0] c);
    clamp_centers = (c > MaxCenters) ? MaxCenters : c;
  endfunction

  function automatic logic [SlotW-1:0] sat16(input logic [CntW-1:0] c);
    sat16 = c[CntW-1] ? {SlotW{1'b1}} : c[SlotW-1:0];
  endfunction

  // item product and bin arithmetic
  assign prod_ext    = {{(SumW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign pop_sum     = {1'b0, pop_q} + {{(PopW+1-OccW){1'b0}}, occ_q};
  assign pop_sum_add = pop_sum;
  assign shortfall   = tgt_q - pop_q;
  assign joins       = (pop_q < tgt_q) &&
                       ({{(PopW+1-OccW){1'b0}}, occ_q} < {shortfall, 1'b0});

  assign mag       = ws_q[SumW-1] ? SumW'(~ws_q + 1'b1) : ws_q;
  assign div_start = cmd_i.mean_start | cmd_i.tgt_start;
  assign div_a     = cmd_i.tgt_start ? {{(SumW-PopW){1'b0}}, una_q} : mag;
  assign div_b     = cmd_i.tgt_start ? {{(PopW-CntW){1'b0}}, cl_q} : pop_q;

  epbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // mean of the closing bin, saturated to the value range
  always_comb begin
    q_mean = (pop_q == '0) ? '0 : quo;
    if (ws_q[SumW-1]) begin
      mean_val = (q_mean > {{(SumW-ValW){1'b0}}, NegLimit}) ? NegLimit
                 : ValW'(~q_mean[ValW-1:0] + 1'b1);
    end else begin
      mean_val = (q_mean > {{(SumW-ValW){1'b0}}, PosLimit}) ? PosLimit
                 : q_mean[ValW-1:0];
    end
  end

  assign ct_load  = clamp_centers(ct_q);
  assign slot_now = (ct_load >= cl_q) ? ct_load - cl_q : '0;
  assign cl_dec   = (cl_q == '0) ? '0 : cl_q - 1'b1;
  assign out_free = !ov_q || out_ready_i;

  // configuration writes
  always_comb begin
    ct_d = ct_q;
    pt_d = pt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CENTER_TOTAL:     ct_d = cfg_data_i[CntW-1:0];
        REG_POPULATION_TOTAL: pt_d = cfg_data_i;
        default:              ;
      endcase
    end
  end
  assign ct_new = clamp_centers(ct_d);

  // bin state and result register
  always_comb begin
    ws_d   = ws_q;
    pop_d  = pop_q;
    tgt_d  = tgt_q;
    una_d  = una_q;
    cl_d   = cl_q;
    open_d = open_q;
    ov_d   = ov_q && !out_ready_i;
    val_d  = val_q;
    slot_d = slot_q;
    fill_d = fill_q;
    end_d  = end_q;

    if (cmd_i.add_item) begin
      ws_d  = ws_q + prod_ext;
      pop_d = pop_sum_add[PopW] ? {PopW{1'b1}} : pop_sum_add[PopW-1:0];
    end
    if (cmd_i.open_bin) begin
      tgt_d  = quo[PopW-1:0];
      ws_d   = prod_ext;
      pop_d  = {{(PopW-OccW){1'b0}}, occ_q};
      open_d = 1'b1;
    end
    if (cmd_i.emit) begin
      ov_d   = 1'b1;
      slot_d = slot_now[SlotW-1:0];
      case (cmd_i.emit_kind)
        EMIT_CLOSE, EMIT_LAST_CLOSE: begin
          val_d  = mean_val;
          cl_d   = cl_dec;
          una_d  = (una_q > pop_q) ? una_q - pop_q : '0;
          fill_d = (cmd_i.emit_kind == EMIT_LAST_CLOSE) ? sat16(cl_dec) : '0;
          end_d  = (cmd_i.emit_kind == EMIT_LAST_CLOSE);
          open_d = 1'b0;
          ws_d   = '0;
          pop_d  = '0;
        end
        EMIT_MARKER: begin
          val_d  = '0;
          fill_d = sat16(cl_q);
          end_d  = 1'b1;
        end
        default: begin
          val_d  = '0;
          fill_d = '0;
          end_d  = 1'b0;
        end
      endcase
    end
    if (cmd_i.reload || cfg_we_i) begin
      ws_d   = '0;
      pop_d  = '0;
      tgt_d  = '0;
      una_d  = pt_d;
      cl_d   = ct_new;
      open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q   <= CenterReset;
      pt_q   <= '0;
      ws_q   <= '0;
      pop_q  <= '0;
      tgt_q  <= '0;
      una_q  <= '0;
      cl_q   <= CenterReset;
      open_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      ct_q   <= ct_d;
      pt_q   <= pt_d;
      ws_q   <= ws_d;
      pop_q  <= pop_d;
      tgt_q  <= tgt_d;
      una_q  <= una_d;
      cl_q   <= cl_d;
      open_q <= open_d;
      ov_q   <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      prod_q <= sample_value_i * $signed({1'b0, occurrences_i});
      occ_q  <= occurrences_i;
      last_q <= final_item_i;
    end
    val_q  <= val_d;
    slot_q <= slot_d;
    fill_q <= fill_d;
    end_q  <= end_d;
  end

  assign out_valid_o     = ov_q;
  assign center_value_o  = val_q;
  assign center_slot_o   = slot_q;
  assign infinite_fill_o = fill_q;
  assign run_end_o       = end_q;

  assign stat_o.bin_open  = open_q;
  assign stat_o.joins     = joins;
  assign stat_o.can_open  = (cl_q != '0) && (una_q != '0);
  assign stat_o.last_item = last_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = out_free;

endmodule

/* hdl/epbc_ctrl.sv */
// controller state machine: sequences join, close, open and final steps
// depends on epbc_pkg
module epbc_ctrl import epbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  epbc_stat_t stat_i,
  output epbc_cmd_t  cmd_o
);

  epbc_state_e state_q, state_d;
  epbc_emit_e  kind_q, kind_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.bin_open && stat_i.joins) begin
          state_d = stat_i.last_item ? ST_TAIL : ST_IDLE;
        end else if (stat_i.bin_open) begin
          state_d = ST_MEAN_DIV;
        end else begin
          state_d = ST_OPEN;
        end
      end
      ST_MEAN_DIV: begin
        if (stat_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = (kind_q == EMIT_CLOSE) ? ST_OPEN : ST_IDLE;
      end
      ST_OPEN: begin
        state_d = stat_i.can_open ? ST_TGT_DIV : ST_TAIL;
      end
      ST_TGT_DIV: begin
        if (stat_i.div_done) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (!stat_i.last_item) begin
          state_d = ST_IDLE;
        end else if (stat_i.bin_open) begin
          state_d = ST_MEAN_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = kind_q;
    in_ready_o      = 1'b0;
    kind_d          = kind_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
      end
      ST_DECIDE: begin
        if (stat_i.bin_open && stat_i.joins) begin
          cmd_o.add_item = 1'b1;
        end else if (stat_i.bin_open) begin
          cmd_o.mean_start = 1'b1;
          kind_d           = EMIT_CLOSE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.reload = (kind_q != EMIT_CLOSE);
        end
      end
      ST_OPEN: begin
        cmd_o.tgt_start = stat_i.can_open;
      end
      ST_TGT_DIV: begin
        cmd_o.open_bin = stat_i.div_done;
      end
      ST_TAIL: begin
        if (stat_i.last_item && stat_i.bin_open) begin
          cmd_o.mean_start = 1'b1;
          kind_d           = EMIT_LAST_CLOSE;
        end else if (stat_i.last_item) begin
          kind_d = EMIT_MARKER;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= EMIT_CLOSE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule
